/* src/psa_pkg.sv */
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types, codes and constants of the paged slot allocator.
// ----------------------------------------------------------------------------
package psa_pkg;

   localparam int MAX_PAGES_DEF      = 8;
   localparam int TOTAL_SLOTS_DEF    = 4096;
   localparam int PAGE_SLOTS_MAX_DEF = 1024;

   localparam int OPCODE_W   = 2;
   localparam int PAGE_W     = 3;
   localparam int SLOT_W     = 10;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam int INIT_SIZE_W = 11;
   localparam int PCT_W      = 7;
   localparam int GROW_W     = 4;

   localparam logic [INIT_SIZE_W-1:0] INIT_SIZE_RST = 11'd64;
   localparam logic [PCT_W-1:0]       PCT_RST       = 7'd90;
   localparam logic [GROW_W-1:0]      GROW_RST      = 4'd4;
   localparam logic [PCT_W-1:0]       PCT_MIN       = 7'd50;
   localparam logic [PCT_W-1:0]       PCT_MAX       = 7'd95;
   localparam logic [GROW_W-1:0]      GROW_MIN      = 4'd1;
   localparam logic [GROW_W-1:0]      GROW_MAX      = 4'd10;

   // floor(x / 100) as (x * RCP_MUL) >> RCP_SHIFT, exact for x below 2**30
   localparam int RCP_SHIFT = 32;
   localparam int RCP_W     = 26;
   localparam logic [RCP_W-1:0] RCP_MUL = 26'd42949673;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_BAD_FREE = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INIT_SIZE = 2'd0,
      CSR_PCT       = 2'd1,
      CSR_GROW      = 2'd2
   } csr_index_type;

   typedef enum logic [4:0] {
      S_INIT, S_INIT_W1, S_INIT_W2, S_INIT_W3,
      S_IDLE,
      S_A_CP, S_A_LF,
      S_SCAN_START, S_SCAN_LATE, S_SCAN_STEP, S_SCAN_END,
      S_OPEN_CHK, S_OPEN_SET, S_OPEN_W1, S_OPEN_W2, S_OPEN_W3,
      S_TAKE_RD, S_TAKE_WR, S_NO_SPACE,
      S_FREE_RD, S_FREE_WR, S_QUERY_RD, S_QUERY_WR, S_NONE
   } state_type;

   typedef enum logic [2:0] {
      PS_CP, PS_LF, PS_SCAN, PS_LAST, PS_PICK, PS_REQ
   } psel_type;

   typedef struct packed {
      psel_type sel;
      logic     load_req;
      logic     init;
      logic     thr_set;
      logic     thr_add;
      logic     pick_cur;
      logic     scan_start;
      logic     scan_early;
      logic     scan_step;
      logic     open_chk;
      logic     open_do;
      logic     take_rd;
      logic     take_wr;
      logic     nospace;
      logic     free_wr;
      logic     query_wr;
      logic     none_wr;
   } cmd_type;

   typedef struct packed {
      logic       cfg_hit;
      opcode_type opcode;
      logic       sel_has_free;
      logic       thr_ok;
      logic       scan_last;
      logic       pick_valid;
      logic       scan_early;
      logic       open_ok;
   } stat_type;

endpackage

/* src/psa_req_if.sv */
// ----------------------------------------------------------------------------
// psa_req_if
// Request channel of the paged slot allocator.
// ----------------------------------------------------------------------------
interface psa_req_if;
   logic                          valid;
   logic                          ready;
   logic [psa_pkg::OPCODE_W-1:0]  opcode;
   logic [psa_pkg::PAGE_W-1:0]    page;
   logic [psa_pkg::SLOT_W-1:0]    slot;

   modport source (output valid, opcode, page, slot, input ready);
   modport sink   (input valid, opcode, page, slot, output ready);
endinterface

/* src/psa_rsp_if.sv */
// ----------------------------------------------------------------------------
// psa_rsp_if
// Response channel of the paged slot allocator.
// ----------------------------------------------------------------------------
interface psa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [psa_pkg::STATUS_W-1:0]  status;
   logic [psa_pkg::PAGE_W-1:0]    alloc_page;
   logic [psa_pkg::SLOT_W-1:0]    alloc_slot;
   logic                          is_assigned;
   logic [psa_pkg::COUNT_W-1:0]   assigned_count;

   modport source (output valid, status, alloc_page, alloc_slot, is_assigned,
                   assigned_count, input ready);
   modport sink   (input valid, status, alloc_page, alloc_slot, is_assigned,
                   assigned_count, output ready);
endinterface

/* src/psa_ctrl.sv */
// ----------------------------------------------------------------------------
// psa_ctrl
// Sequencer of the allocator: handshakes and per-request step order.
// ----------------------------------------------------------------------------
module psa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  psa_pkg::stat_type stat,
   output psa_pkg::cmd_type  cmd
);

   psa_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;
   logic               finish;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign req_ready = (state_ff == psa_pkg::S_IDLE) && !stat.cfg_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psa_pkg::S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.sel  = psa_pkg::PS_PICK;
      finish   = 1'b0;
      case (state_ff)
         psa_pkg::S_INIT: begin
            cmd.init = 1'b1;
            state_in = psa_pkg::S_INIT_W1;
         end
         psa_pkg::S_INIT_W1: state_in = psa_pkg::S_INIT_W2;
         psa_pkg::S_INIT_W2: state_in = psa_pkg::S_INIT_W3;
         psa_pkg::S_INIT_W3: begin
            cmd.thr_set = 1'b1;
            state_in    = psa_pkg::S_IDLE;
         end
         psa_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               case (stat.opcode)
                  psa_pkg::OP_ALLOC: state_in = psa_pkg::S_A_CP;
                  psa_pkg::OP_FREE:  state_in = psa_pkg::S_FREE_RD;
                  psa_pkg::OP_QUERY: state_in = psa_pkg::S_QUERY_RD;
                  default:           state_in = psa_pkg::S_NONE;
               endcase
            end
         end
         psa_pkg::S_A_CP: begin
            cmd.sel      = psa_pkg::PS_CP;
            cmd.pick_cur = 1'b1;
            state_in     = stat.sel_has_free ? psa_pkg::S_TAKE_RD : psa_pkg::S_A_LF;
         end
         psa_pkg::S_A_LF: begin
            cmd.sel      = psa_pkg::PS_LF;
            cmd.pick_cur = 1'b1;
            if (stat.sel_has_free) begin
               state_in = psa_pkg::S_TAKE_RD;
            end else if (stat.thr_ok) begin
               state_in = psa_pkg::S_SCAN_START;
            end else begin
               state_in = psa_pkg::S_OPEN_CHK;
            end
         end
         psa_pkg::S_SCAN_START: begin
            cmd.scan_start = 1'b1;
            cmd.scan_early = 1'b1;
            state_in       = psa_pkg::S_SCAN_STEP;
         end
         psa_pkg::S_SCAN_LATE: begin
            cmd.scan_start = 1'b1;
            state_in       = psa_pkg::S_SCAN_STEP;
         end
         psa_pkg::S_SCAN_STEP: begin
            cmd.sel       = psa_pkg::PS_SCAN;
            cmd.scan_step = 1'b1;
            if (stat.scan_last) state_in = psa_pkg::S_SCAN_END;
         end
         psa_pkg::S_SCAN_END: begin
            if (stat.pick_valid) begin
               state_in = psa_pkg::S_TAKE_RD;
            end else if (stat.scan_early) begin
               state_in = psa_pkg::S_OPEN_CHK;
            end else begin
               state_in = psa_pkg::S_NO_SPACE;
            end
         end
         psa_pkg::S_OPEN_CHK: begin
            cmd.sel      = psa_pkg::PS_LAST;
            cmd.open_chk = 1'b1;
            state_in     = stat.open_ok ? psa_pkg::S_OPEN_SET : psa_pkg::S_SCAN_LATE;
         end
         psa_pkg::S_OPEN_SET: begin
            cmd.open_do = 1'b1;
            state_in    = psa_pkg::S_OPEN_W1;
         end
         psa_pkg::S_OPEN_W1: state_in = psa_pkg::S_OPEN_W2;
         psa_pkg::S_OPEN_W2: state_in = psa_pkg::S_OPEN_W3;
         psa_pkg::S_OPEN_W3: begin
            cmd.thr_add = 1'b1;
            state_in    = psa_pkg::S_TAKE_RD;
         end
         psa_pkg::S_TAKE_RD: begin
            cmd.take_rd = 1'b1;
            state_in    = psa_pkg::S_TAKE_WR;
         end
         psa_pkg::S_TAKE_WR: begin
            if (out_free) begin
               cmd.take_wr = 1'b1;
               finish      = 1'b1;
            end
         end
         psa_pkg::S_NO_SPACE: begin
            if (out_free) begin
               cmd.nospace = 1'b1;
               finish      = 1'b1;
            end
         end
         psa_pkg::S_FREE_RD: begin
            cmd.sel  = psa_pkg::PS_REQ;
            state_in = psa_pkg::S_FREE_WR;
         end
         psa_pkg::S_FREE_WR: begin
            cmd.sel = psa_pkg::PS_REQ;
            if (out_free) begin
               cmd.free_wr = 1'b1;
               finish      = 1'b1;
            end
         end
         psa_pkg::S_QUERY_RD: begin
            cmd.sel  = psa_pkg::PS_REQ;
            state_in = psa_pkg::S_QUERY_WR;
         end
         psa_pkg::S_QUERY_WR: begin
            cmd.sel = psa_pkg::PS_REQ;
            if (out_free) begin
               cmd.query_wr = 1'b1;
               finish       = 1'b1;
            end
         end
         psa_pkg::S_NONE: begin
            if (out_free) begin
               cmd.none_wr = 1'b1;
               finish      = 1'b1;
            end
         end
         default: state_in = psa_pkg::S_INIT;
      endcase
      if (finish) state_in = psa_pkg::S_IDLE;
      // a register write rebuilds the pool from scratch
      if (stat.cfg_hit) begin
         cmd      = '0;
         cmd.sel  = psa_pkg::PS_PICK;
         finish   = 1'b0;
         state_in = psa_pkg::S_INIT;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (finish) rsp_valid_in = 1'b1;
   end

endmodule

/* src/psa_datapath.sv */
// ----------------------------------------------------------------------------
// psa_datapath
// Page table, free stack and assigned bitmap memories, result register.
// ----------------------------------------------------------------------------
module psa_datapath #(
   parameter int MAX_PAGES      = psa_pkg::MAX_PAGES_DEF,
   parameter int TOTAL_SLOTS    = psa_pkg::TOTAL_SLOTS_DEF,
   parameter int PAGE_SLOTS_MAX = psa_pkg::PAGE_SLOTS_MAX_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [psa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [psa_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [psa_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic [psa_pkg::PAGE_W-1:0]        req_page,
   input  logic [psa_pkg::SLOT_W-1:0]        req_slot,
   output logic [psa_pkg::STATUS_W-1:0]      rsp_status,
   output logic [psa_pkg::PAGE_W-1:0]        rsp_alloc_page,
   output logic [psa_pkg::SLOT_W-1:0]        rsp_alloc_slot,
   output logic                              rsp_is_assigned,
   output logic [psa_pkg::COUNT_W-1:0]       rsp_assigned_count,
   input  psa_pkg::cmd_type                  cmd,
   output psa_pkg::stat_type                 stat
);

   localparam int CAP = (PAGE_SLOTS_MAX < TOTAL_SLOTS) ? PAGE_SLOTS_MAX : TOTAL_SLOTS;
   localparam int SW  = $clog2(CAP + 1);
   localparam int AW  = $clog2(TOTAL_SLOTS);
   localparam int BW  = $clog2(TOTAL_SLOTS + 1);
   localparam int PGW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int CNW = $clog2(MAX_PAGES + 1);
   localparam int SLW = (CAP > 1) ? $clog2(CAP) : 1;
   localparam int PRW = SW + psa_pkg::PCT_W;
   localparam int RW  = PRW + psa_pkg::RCP_W;
   localparam int GW  = SW + psa_pkg::GROW_W;

   // configuration
   logic [psa_pkg::INIT_SIZE_W-1:0] cfg_size_ff;
   logic [psa_pkg::PCT_W-1:0]       cfg_pct_ff;
   logic [psa_pkg::GROW_W-1:0]      cfg_grow_ff;
   logic [SW-1:0]                   size0;
   logic [psa_pkg::PCT_W-1:0]       pct_eff;
   logic [psa_pkg::GROW_W-1:0]      grow_eff;

   // page table
   logic [SW-1:0]  size_ff [MAX_PAGES];
   logic [SW-1:0]  fc_ff   [MAX_PAGES];
   logic [SW-1:0]  lw_ff   [MAX_PAGES];
   logic [BW-1:0]  base_ff [MAX_PAGES];
   logic [CNW-1:0] count_ff;
   logic [PGW-1:0] cp_ff, lf_ff, pick_ff, scan_idx_ff;
   logic [BW-1:0]  total_ff, thr_ff;

   // request and step registers
   logic [psa_pkg::PAGE_W-1:0]   pg_ff;
   logic [psa_pkg::SLOT_W-1:0]   sl_ff;
   logic [SW-1:0]  best_ff;
   logic           pick_valid_ff, early_ff;
   logic [GW-1:0]  grow_ff;
   logic [BW-1:0]  nb_ff;
   logic [SW-1:0]  new_size_ff;
   logic [PRW-1:0] prod_ff;
   logic [SW-1:0]  q_ff;
   logic [SW-1:0]  tk_pos_ff, tk_lw_ff;
   logic [RW-1:0]  rcp_prod;

   // memories
   logic [SLW-1:0] stack_mem [TOTAL_SLOTS];
   logic           bit_mem   [TOTAL_SLOTS];
   logic [SLW-1:0] stack_q_ff;
   logic           bit_q_ff;

   // result register
   logic [psa_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [psa_pkg::PAGE_W-1:0]   rsp_page_ff;
   logic [psa_pkg::SLOT_W-1:0]   rsp_slot_ff;
   logic                         rsp_isa_ff;
   logic [psa_pkg::COUNT_W-1:0]  rsp_count_ff;

   logic [PGW-1:0] idx;
   logic [SW-1:0]  sel_size, sel_fc, sel_lw;
   logic [BW-1:0]  sel_base;
   logic           pg_ok, req_ok, lw_ok, free_ok, better;
   logic [31:0]    base_next, left, sz32;
   logic [SW-1:0]  fcn, new_sz;
   logic [SLW-1:0] take_slot;
   logic [AW-1:0]  stk_rd_addr, stk_wr_addr, bit_rd_addr, bit_wr_addr;
   logic           bit_we, bit_wd;

   // clamped register values
   always_comb begin
      if (cfg_size_ff == '0) begin
         size0 = SW'(1);
      end else if (32'(cfg_size_ff) > 32'(CAP)) begin
         size0 = SW'(CAP);
      end else begin
         size0 = SW'(cfg_size_ff);
      end
      pct_eff = cfg_pct_ff;
      if (cfg_pct_ff < psa_pkg::PCT_MIN) pct_eff = psa_pkg::PCT_MIN;
      if (cfg_pct_ff > psa_pkg::PCT_MAX) pct_eff = psa_pkg::PCT_MAX;
      grow_eff = cfg_grow_ff;
      if (cfg_grow_ff < psa_pkg::GROW_MIN) grow_eff = psa_pkg::GROW_MIN;
      if (cfg_grow_ff > psa_pkg::GROW_MAX) grow_eff = psa_pkg::GROW_MAX;
   end

   // single read port of the page table
   always_comb begin
      case (cmd.sel)
         psa_pkg::PS_CP:   idx = (CNW'(cp_ff) < count_ff) ? cp_ff : '0;
         psa_pkg::PS_LF:   idx = (CNW'(lf_ff) < count_ff) ? lf_ff : '0;
         psa_pkg::PS_SCAN: idx = scan_idx_ff;
         psa_pkg::PS_LAST: idx = PGW'(count_ff - CNW'(1));
         psa_pkg::PS_REQ:  idx = PGW'(pg_ff);
         default:          idx = pick_ff;
      endcase
   end

   assign sel_size = size_ff[idx];
   assign sel_fc   = fc_ff[idx];
   assign sel_lw   = lw_ff[idx];
   assign sel_base = base_ff[idx];

   assign pg_ok   = 32'(pg_ff) < 32'(count_ff);
   assign req_ok  = pg_ok && (32'(sl_ff) < 32'(sel_size));
   // slots below the low-water mark were never handed out since the page opened
   assign lw_ok   = 32'(sl_ff) >= 32'(sel_lw);
   assign free_ok = req_ok && lw_ok && bit_q_ff && (sel_fc < sel_size);
   assign better  = sel_fc > best_ff;

   assign base_next = 32'(sel_base) + 32'(sel_size);
   assign left      = 32'(TOTAL_SLOTS) - 32'(nb_ff);
   always_comb begin
      sz32 = 32'(grow_ff);
      if (sz32 > 32'(CAP)) sz32 = 32'(CAP);
      if (sz32 > left) sz32 = left;
      new_sz = SW'(sz32);
   end

   assign fcn       = sel_fc - SW'(1);
   assign take_slot = (tk_pos_ff < tk_lw_ff) ? SLW'(tk_pos_ff) : stack_q_ff;
   assign rcp_prod  = RW'(prod_ff) * RW'(psa_pkg::RCP_MUL);

   assign stk_rd_addr = AW'(32'(sel_base) + 32'(fcn));
   assign stk_wr_addr = AW'(32'(sel_base) + 32'(sel_fc));
   assign bit_rd_addr = AW'(32'(sel_base) + 32'(sl_ff));
   assign bit_wr_addr = cmd.take_wr ? AW'(32'(sel_base) + 32'(take_slot)) : bit_rd_addr;
   assign bit_we      = cmd.take_wr || (cmd.free_wr && free_ok);
   assign bit_wd      = cmd.take_wr;

   always_ff @(posedge clock) begin
      // popped entry is held while the previous response waits on a stalled receiver
      if (cmd.take_rd) stack_q_ff <= stack_mem[stk_rd_addr];
      if (cmd.free_wr && free_ok) stack_mem[stk_wr_addr] <= SLW'(sl_ff);
   end

   always_ff @(posedge clock) begin
      bit_q_ff <= bit_mem[bit_rd_addr];
      if (bit_we) bit_mem[bit_wr_addr] <= bit_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_size_ff <= psa_pkg::INIT_SIZE_RST;
         cfg_pct_ff  <= psa_pkg::PCT_RST;
         cfg_grow_ff <= psa_pkg::GROW_RST;
      end else if (csr_we) begin
         case (csr_index)
            psa_pkg::CSR_INIT_SIZE: cfg_size_ff <= csr_wdata;
            psa_pkg::CSR_PCT:       cfg_pct_ff  <= psa_pkg::PCT_W'(csr_wdata);
            psa_pkg::CSR_GROW:      cfg_grow_ff <= psa_pkg::GROW_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   // threshold term: floor(size * percent / 100), two stages
   always_ff @(posedge clock) begin
      prod_ff <= PRW'(new_size_ff) * PRW'(pct_eff);
      q_ff    <= SW'(rcp_prod >> psa_pkg::RCP_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         pg_ff <= req_page;
         sl_ff <= req_slot;
      end
      if (cmd.init) begin
         for (int i = 0; i < MAX_PAGES; i++) begin
            size_ff[i] <= '0;
            fc_ff[i]   <= '0;
            lw_ff[i]   <= '0;
            base_ff[i] <= '0;
         end
         size_ff[0]  <= size0;
         fc_ff[0]    <= size0;
         lw_ff[0]    <= size0;
         count_ff    <= CNW'(1);
         cp_ff       <= '0;
         lf_ff       <= '0;
         total_ff    <= '0;
         new_size_ff <= size0;
      end
      if (cmd.thr_set) thr_ff <= BW'(q_ff);
      if (cmd.thr_add) thr_ff <= thr_ff + BW'(q_ff);
      if (cmd.pick_cur) pick_ff <= idx;
      if (cmd.scan_start) begin
         scan_idx_ff   <= PGW'(count_ff - CNW'(1));
         best_ff       <= '0;
         pick_valid_ff <= 1'b0;
         early_ff      <= cmd.scan_early;
      end
      if (cmd.scan_step) begin
         if (better) begin
            best_ff       <= sel_fc;
            pick_ff       <= idx;
            pick_valid_ff <= 1'b1;
         end
         scan_idx_ff <= scan_idx_ff - PGW'(1);
      end
      if (cmd.open_chk) begin
         grow_ff <= GW'(sel_size) * GW'(grow_eff);
         nb_ff   <= BW'(base_next);
      end
      if (cmd.open_do) begin
         base_ff[PGW'(count_ff)] <= nb_ff;
         size_ff[PGW'(count_ff)] <= new_sz;
         fc_ff[PGW'(count_ff)]   <= new_sz;
         lw_ff[PGW'(count_ff)]   <= new_sz;
         count_ff    <= count_ff + CNW'(1);
         cp_ff       <= PGW'(count_ff);
         pick_ff     <= PGW'(count_ff);
         new_size_ff <= new_sz;
      end
      if (cmd.take_rd) begin
         fc_ff[idx] <= fcn;
         if (fcn < sel_lw) lw_ff[idx] <= fcn;
         tk_pos_ff <= fcn;
         tk_lw_ff  <= sel_lw;
      end
      if (cmd.take_wr) begin
         total_ff       <= total_ff + BW'(1);
         cp_ff          <= pick_ff;
         rsp_status_ff  <= psa_pkg::ST_OK;
         rsp_page_ff    <= psa_pkg::PAGE_W'(pick_ff);
         rsp_slot_ff    <= psa_pkg::SLOT_W'(take_slot);
         rsp_isa_ff     <= 1'b0;
         rsp_count_ff   <= psa_pkg::COUNT_W'(total_ff + BW'(1));
      end
      if (cmd.nospace) begin
         rsp_status_ff <= psa_pkg::ST_NO_SPACE;
         rsp_page_ff   <= '0;
         rsp_slot_ff   <= '0;
         rsp_isa_ff    <= 1'b0;
         rsp_count_ff  <= psa_pkg::COUNT_W'(total_ff);
      end
      if (cmd.free_wr) begin
         rsp_page_ff <= '0;
         rsp_slot_ff <= '0;
         rsp_isa_ff  <= 1'b0;
         if (free_ok) begin
            fc_ff[idx]    <= sel_fc + SW'(1);
            lf_ff         <= idx;
            rsp_status_ff <= psa_pkg::ST_OK;
            if (total_ff != '0) begin
               total_ff     <= total_ff - BW'(1);
               rsp_count_ff <= psa_pkg::COUNT_W'(total_ff - BW'(1));
            end else begin
               rsp_count_ff <= psa_pkg::COUNT_W'(total_ff);
            end
         end else begin
            rsp_status_ff <= psa_pkg::ST_BAD_FREE;
            rsp_count_ff  <= psa_pkg::COUNT_W'(total_ff);
         end
      end
      if (cmd.query_wr) begin
         rsp_status_ff <= psa_pkg::ST_OK;
         rsp_page_ff   <= '0;
         rsp_slot_ff   <= '0;
         rsp_isa_ff    <= req_ok && lw_ok && bit_q_ff;
         rsp_count_ff  <= psa_pkg::COUNT_W'(total_ff);
      end
      if (cmd.none_wr) begin
         rsp_status_ff <= psa_pkg::ST_OK;
         rsp_page_ff   <= '0;
         rsp_slot_ff   <= '0;
         rsp_isa_ff    <= 1'b0;
         rsp_count_ff  <= psa_pkg::COUNT_W'(total_ff);
      end
   end

   always_comb begin
      stat.cfg_hit      = csr_we && (csr_index == psa_pkg::CSR_INIT_SIZE ||
                                     csr_index == psa_pkg::CSR_PCT ||
                                     csr_index == psa_pkg::CSR_GROW);
      stat.opcode       = psa_pkg::opcode_type'(req_opcode);
      stat.sel_has_free = sel_fc != '0;
      stat.thr_ok       = (32'(total_ff) + 32'd1) < 32'(thr_ff);
      stat.scan_last    = (scan_idx_ff == '0) ||
                          (early_ff && better && 32'(sel_fc) >= 32'(count_ff));
      stat.pick_valid   = pick_valid_ff;
      stat.scan_early   = early_ff;
      stat.open_ok      = (32'(count_ff) < 32'(MAX_PAGES)) &&
                          (base_next < 32'(TOTAL_SLOTS));
   end

   assign rsp_status         = rsp_status_ff;
   assign rsp_alloc_page     = rsp_page_ff;
   assign rsp_alloc_slot     = rsp_slot_ff;
   assign rsp_is_assigned    = rsp_isa_ff;
   assign rsp_assigned_count = rsp_count_ff;

endmodule

/* src/paged_slot_allocator.sv */
// ----------------------------------------------------------------------------
// paged_slot_allocator
// Fixed-size slot allocator over growing pages with per-page free stacks.
// ----------------------------------------------------------------------------
// Requests arrive on req_if (opcode allocate, free or query, with page and
// slot for free and query); one response per request leaves on rsp_if with
// status, the allocated page and slot, the query answer and the assigned
// count after the request.
// An allocation tries the current page, then the last-freed page. If both
// are full, it scans the page table for a page with free slots while the
// count after the allocation stays below the threshold, else it opens a
// new page; when that fails it tries the other. The scan walks the page
// table one entry a cycle; the bitmap and free stack have registered reads
// and separate read and write ports. One request is worked on at a time;
// the next is accepted as soon as the previous response is registered,
// even while it still waits on rsp_if. A stalled receiver holds the response
// and stops the next request at its final step. Reset, or a write to any
// register over csr_*, rebuilds page zero and the threshold, and no request is taken until that is done.
// ----------------------------------------------------------------------------
module paged_slot_allocator #(
   parameter int MAX_PAGES      = psa_pkg::MAX_PAGES_DEF,
   parameter int TOTAL_SLOTS    = psa_pkg::TOTAL_SLOTS_DEF,
   parameter int PAGE_SLOTS_MAX = psa_pkg::PAGE_SLOTS_MAX_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   psa_req_if.sink                        req_if,
   psa_rsp_if.source                      rsp_if,
   input  logic                           csr_we,
   input  logic [psa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [psa_pkg::CSR_DATA_W-1:0] csr_wdata
);

   psa_pkg::cmd_type  cmd;
   psa_pkg::stat_type stat;

   psa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   psa_datapath #(
      .MAX_PAGES      (MAX_PAGES),
      .TOTAL_SLOTS    (TOTAL_SLOTS),
      .PAGE_SLOTS_MAX (PAGE_SLOTS_MAX)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_opcode         (req_if.opcode),
      .req_page           (req_if.page),
      .req_slot           (req_if.slot),
      .rsp_status         (rsp_if.status),
      .rsp_alloc_page     (rsp_if.alloc_page),
      .rsp_alloc_slot     (rsp_if.alloc_slot),
      .rsp_is_assigned    (rsp_if.is_assigned),
      .rsp_assigned_count (rsp_if.assigned_count),
      .cmd                (cmd),
      .stat               (stat)
   );

endmodule
